>>> hdl/wpd_pkg.sv
// Shared constants and types for the Walsh-4 spread 4-PAM demodulator.
// Depends on nothing; every other file of the block refers to it by scoped names.
package wpd_pkg;

  localparam int SAMPLE_W = 12;
  localparam int NUM_SAMPLES = 4;
  localparam int SUM_W = 14;
  localparam int NUM_THR = 12;
  localparam int THR_IDX_W = 4;
  localparam int LVL_W = 4;
  localparam int ACC_W = 7;
  localparam int NUM_ROWS = 4;
  localparam int POS_W = 2;
  localparam int SYM_W = 8;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam int PROD_W = 2 * SAMPLE_W;
  localparam int RECIP3_W = 16;
  localparam int RECIP3_SHIFT = 17;
  localparam logic [RECIP3_W-1:0] RECIP3 = 16'd43691;
  localparam logic [SAMPLE_W-1:0] LOW_RESET = 12'd0;
  localparam logic [SAMPLE_W-1:0] HIGH_RESET = 12'd4095;

  typedef enum logic {
    REG_LOW_LEVEL  = 1'b0,
    REG_HIGH_LEVEL = 1'b1
  } reg_idx_t;

  typedef logic [NUM_THR-1:0][SAMPLE_W-1:0] thr_arr_t;

  // One quantized chip moving from the chip level pipeline to the Walsh stage.
  typedef struct packed {
    logic             valid;
    logic             start;
    logic [LVL_W-1:0] level;
  } lvl_xfer_t;

endpackage

>>> hdl/wpd_thresh.sv
// Configuration registers and the 12 chip level thresholds of the demodulator.
// Uses wpd_pkg; refreshes the thresholds through one multiplier after each write.
module wpd_thresh (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [wpd_pkg::PADDR_W-1:0]    paddr,
  input  logic [wpd_pkg::PDATA_W-1:0]    pwdata,
  output logic [wpd_pkg::PDATA_W-1:0]    prdata,
  output wpd_pkg::thr_arr_t              thr,
  output logic                           busy
);

  function automatic logic [wpd_pkg::SAMPLE_W-1:0] thr_base(
    input logic [wpd_pkg::THR_IDX_W-1:0] idx
  );
    logic [wpd_pkg::SAMPLE_W-1:0] b;
    case (idx)
      4'd0:    b = 12'd171;
      4'd1:    b = 12'd512;
      4'd2:    b = 12'd853;
      4'd3:    b = 12'd1195;
      4'd4:    b = 12'd1536;
      4'd5:    b = 12'd1877;
      4'd6:    b = 12'd2218;
      4'd7:    b = 12'd2560;
      4'd8:    b = 12'd2901;
      4'd9:    b = 12'd3243;
      4'd10:   b = 12'd3584;
      4'd11:   b = 12'd3925;
      default: b = 12'd0;
    endcase
    return b;
  endfunction

  logic [wpd_pkg::SAMPLE_W-1:0]  low_level;
  logic [wpd_pkg::SAMPLE_W-1:0]  high_level;
  logic                          run;
  logic [wpd_pkg::THR_IDX_W-1:0] idx;
  logic                          prod_valid;
  logic [wpd_pkg::THR_IDX_W-1:0] prod_idx;
  logic [wpd_pkg::PROD_W-1:0]    prod;
  logic                          wr;
  wpd_pkg::reg_idx_t             wr_reg;
  logic [wpd_pkg::SAMPLE_W-1:0]  span;
  logic [wpd_pkg::PROD_W:0]      quot_sum;
  logic [wpd_pkg::SAMPLE_W:0]    thr_sum;

  assign wr = psel && penable && pwrite;
  assign wr_reg = wpd_pkg::reg_idx_t'(paddr[2]);

  always_comb begin
    case (wpd_pkg::reg_idx_t'(paddr[2]))
      wpd_pkg::REG_LOW_LEVEL:
        prdata = {{(wpd_pkg::PDATA_W-wpd_pkg::SAMPLE_W){1'b0}}, low_level};
      wpd_pkg::REG_HIGH_LEVEL:
        prdata = {{(wpd_pkg::PDATA_W-wpd_pkg::SAMPLE_W){1'b0}}, high_level};
      default:
        prdata = '0;
    endcase
  end

  // An empty range gives a zero span, so every threshold becomes low_level.
  assign span = (high_level > low_level) ? (high_level - low_level) : '0;

  // Division by 4095 of a 24-bit product: (x + (x >> 12) + 1) >> 12.
  assign quot_sum = {1'b0, prod} + (wpd_pkg::PROD_W+1)'(prod >> wpd_pkg::SAMPLE_W)
                    + (wpd_pkg::PROD_W+1)'(1);
  assign thr_sum = {1'b0, low_level}
                   + {1'b0, quot_sum[wpd_pkg::PROD_W-1:wpd_pkg::SAMPLE_W]};

  assign busy = run || prod_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_level <= wpd_pkg::LOW_RESET;
      high_level <= wpd_pkg::HIGH_RESET;
      run <= 1'b0;
      idx <= '0;
      prod_valid <= 1'b0;
      for (int i = 0; i < wpd_pkg::NUM_THR; i++) begin
        thr[i] <= thr_base(wpd_pkg::THR_IDX_W'(i));
      end
    end else begin
      if (wr) begin
        case (wr_reg)
          wpd_pkg::REG_LOW_LEVEL:  low_level <= pwdata[wpd_pkg::SAMPLE_W-1:0];
          wpd_pkg::REG_HIGH_LEVEL: high_level <= pwdata[wpd_pkg::SAMPLE_W-1:0];
          default: ;
        endcase
        run <= 1'b1;
        idx <= '0;
      end else if (run) begin
        idx <= idx + 1'b1;
        if (idx == wpd_pkg::THR_IDX_W'(wpd_pkg::NUM_THR - 1)) begin
          run <= 1'b0;
        end
      end
      prod_valid <= run;
      if (prod_valid) begin
        thr[prod_idx] <= thr_sum[wpd_pkg::SAMPLE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= span * thr_base(idx);
    prod_idx <= idx;
  end

endmodule

>>> hdl/wpd_dev_lane.sv
// One deviation lane: registered absolute distance of a sample from the chip mean.
// Uses wpd_pkg for widths; four copies run side by side in wpd_chip_level.
module wpd_dev_lane (
  input  logic                         clk,
  input  logic                         load,
  input  logic [wpd_pkg::SAMPLE_W-1:0] sample,
  input  logic [wpd_pkg::SAMPLE_W-1:0] mean,
  output logic [wpd_pkg::SAMPLE_W-1:0] dev
);

  always_ff @(posedge clk) begin
    if (load) begin
      dev <= (sample > mean) ? (sample - mean) : (mean - sample);
    end
  end

endmodule

>>> hdl/wpd_chip_level.sv
// Chip level pipeline: sum, four deviation lanes, outlier drop, divide by 3, quantize.
// Uses wpd_pkg and wpd_dev_lane; thresholds come from wpd_thresh.
module wpd_chip_level (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [wpd_pkg::SAMPLE_W-1:0] sample_a,
  input  logic [wpd_pkg::SAMPLE_W-1:0] sample_b,
  input  logic [wpd_pkg::SAMPLE_W-1:0] sample_c,
  input  logic [wpd_pkg::SAMPLE_W-1:0] sample_d,
  input  logic                         symbol_start,
  input  wpd_pkg::thr_arr_t            thr,
  output wpd_pkg::lvl_xfer_t           lvl,
  input  logic                         lvl_ready
);

  localparam int NS = wpd_pkg::NUM_SAMPLES;
  localparam int SW = wpd_pkg::SAMPLE_W;

  logic [SW-1:0] in_s [NS];

  logic v1, v2, v3, v4, v5;
  logic r1, r2, r3, r4, r5;

  logic [SW-1:0]               s1 [NS];
  logic [wpd_pkg::SUM_W-1:0]   sum1;
  logic                        start1;
  logic [SW-1:0]               s2 [NS];
  logic [SW-1:0]               dev2 [NS];
  logic [wpd_pkg::SUM_W-1:0]   sum2;
  logic                        start2;
  logic [wpd_pkg::SUM_W-1:0]   rem3;
  logic                        start3;
  logic [SW-1:0]               avg4;
  logic                        start4;
  logic [wpd_pkg::LVL_W-1:0]   lvl5;
  logic                        start5;

  logic [wpd_pkg::SUM_W-1:0]   in_sum;
  logic [1:0]                  worst;
  logic [SW-1:0]               max_dev;
  logic [wpd_pkg::SUM_W+wpd_pkg::RECIP3_W-1:0] prod3;
  logic [wpd_pkg::LVL_W-1:0]   count;

  assign in_s[0] = sample_a;
  assign in_s[1] = sample_b;
  assign in_s[2] = sample_c;
  assign in_s[3] = sample_d;

  assign r5 = !v5 || lvl_ready;
  assign r4 = !v4 || r5;
  assign r3 = !v3 || r4;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign in_ready = r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
      if (r5) v5 <= v4;
    end
  end

  always_comb begin
    in_sum = '0;
    for (int i = 0; i < NS; i++) begin
      in_sum = in_sum + wpd_pkg::SUM_W'(in_s[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (r1 && in_valid) begin
      s1 <= in_s;
      sum1 <= in_sum;
      start1 <= symbol_start;
    end
  end

  for (genvar g = 0; g < NS; g++) begin : g_lane
    wpd_dev_lane u_lane (
      .clk    (clk),
      .load   (r2 && v1),
      .sample (s1[g]),
      .mean   (sum1[wpd_pkg::SUM_W-1:2]),
      .dev    (dev2[g])
    );
  end

  always_ff @(posedge clk) begin
    if (r2 && v1) begin
      s2 <= s1;
      sum2 <= sum1;
      start2 <= start1;
    end
  end

  // The first sample with the strictly largest deviation is dropped.
  always_comb begin
    worst = '0;
    max_dev = '0;
    for (int i = 0; i < NS; i++) begin
      if (dev2[i] > max_dev) begin
        max_dev = dev2[i];
        worst = 2'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (r3 && v2) begin
      rem3 <= sum2 - wpd_pkg::SUM_W'(s2[worst]);
      start3 <= start2;
    end
  end

  assign prod3 = rem3 * wpd_pkg::RECIP3;

  always_ff @(posedge clk) begin
    if (r4 && v3) begin
      avg4 <= prod3[wpd_pkg::RECIP3_SHIFT+SW-1:wpd_pkg::RECIP3_SHIFT];
      start4 <= start3;
    end
  end

  // The thresholds never decrease, so the level is the count of those reached.
  always_comb begin
    count = '0;
    for (int i = 0; i < wpd_pkg::NUM_THR; i++) begin
      count = count + wpd_pkg::LVL_W'(avg4 >= thr[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (r5 && v4) begin
      lvl5 <= count;
      start5 <= start4;
    end
  end

  assign lvl.valid = v5;
  assign lvl.start = start5;
  assign lvl.level = lvl5;

endmodule

>>> hdl/wpd_walsh.sv
// Inverse 4x4 Walsh accumulation, 4-PAM slicing and the symbol output register.
// Uses wpd_pkg; takes quantized chips from wpd_chip_level.
module wpd_walsh (
  input  logic                      clk,
  input  logic                      rst,
  input  wpd_pkg::lvl_xfer_t        lvl,
  output logic                      lvl_ready,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [wpd_pkg::SYM_W-1:0] symbol
);

  localparam int AW = wpd_pkg::ACC_W;

  function automatic logic walsh_neg(input int row, input logic [wpd_pkg::POS_W-1:0] pos);
    logic [3:0] mask;
    case (row)
      0:       mask = 4'b0000;
      1:       mask = 4'b1100;
      2:       mask = 4'b0110;
      3:       mask = 4'b1010;
      default: mask = 4'b0000;
    endcase
    return mask[pos];
  endfunction

  function automatic logic [1:0] slice_pam(input logic signed [AW-1:0] v);
    logic [1:0] r;
    if (v <= -7'sd2) begin
      r = 2'd0;
    end else if (v < 7'sd0) begin
      r = 2'd1;
    end else if (v < 7'sd2) begin
      r = 2'd2;
    end else begin
      r = 2'd3;
    end
    return r;
  endfunction

  logic [wpd_pkg::POS_W-1:0] pos;
  logic signed [AW-1:0]      acc [wpd_pkg::NUM_ROWS];
  logic signed [AW-1:0]      acc_next [wpd_pkg::NUM_ROWS];
  logic [wpd_pkg::POS_W-1:0] pos_eff;
  logic signed [AW-1:0]      chip;
  logic signed [AW-1:0]      est;
  logic [wpd_pkg::SYM_W-1:0] symbol_next;
  logic                      take;
  logic                      last;

  assign lvl_ready = !out_valid || !out_stall;
  assign take = lvl.valid && lvl_ready;
  assign pos_eff = lvl.start ? '0 : pos;
  assign last = (pos_eff == {wpd_pkg::POS_W{1'b1}});
  assign chip = $signed({2'b00, lvl.level, 1'b0}) - 7'sd12;

  always_comb begin
    symbol_next = '0;
    est = '0;
    for (int i = 0; i < wpd_pkg::NUM_ROWS; i++) begin
      acc_next[i] = (lvl.start ? '0 : acc[i]) + (walsh_neg(i, pos_eff) ? -chip : chip);
      est = acc_next[i] >>> 2;
      symbol_next[wpd_pkg::SYM_W-1-2*i -: 2] = slice_pam(est);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < wpd_pkg::NUM_ROWS; i++) begin
        acc[i] <= '0;
      end
    end else begin
      if (take && last) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (take) begin
        pos <= last ? '0 : pos_eff + 1'b1;
        for (int i = 0; i < wpd_pkg::NUM_ROWS; i++) begin
          acc[i] <= last ? '0 : acc_next[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && last) begin
      symbol <= symbol_next;
    end
  end

endmodule

>>> hdl/walsh_4pam_demodulator.sv
// Walsh-4 spread 4-PAM demodulator, top level.
// Uses wpd_pkg, wpd_thresh, wpd_chip_level and wpd_walsh.
//
// The block takes one chip (four ADC samples) per cycle while in_stall is low and emits
// one 8-bit symbol after every fourth chip of a symbol; after its last chip is accepted, a
// symbol passes through the five-stage chip level pipeline and the Walsh accumulation stage
// into the output register. A finished symbol may wait in the output register while new
// chips keep flowing until the pipeline fills. After every write to low_level or
// high_level, in_stall stays high while the threshold unit recomputes the 12 thresholds
// one per cycle through its single multiplier.
module walsh_4pam_demodulator (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [wpd_pkg::SAMPLE_W-1:0] sample_a,
  input  logic [wpd_pkg::SAMPLE_W-1:0] sample_b,
  input  logic [wpd_pkg::SAMPLE_W-1:0] sample_c,
  input  logic [wpd_pkg::SAMPLE_W-1:0] sample_d,
  input  logic                         symbol_start,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [wpd_pkg::SYM_W-1:0]    symbol,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [wpd_pkg::PADDR_W-1:0]  paddr,
  input  logic [wpd_pkg::PDATA_W-1:0]  pwdata,
  output logic [wpd_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  wpd_pkg::thr_arr_t  thr;
  wpd_pkg::lvl_xfer_t lvl;
  logic               busy;
  logic               front_ready;
  logic               lvl_ready;

  assign pready = 1'b1;
  assign in_stall = busy || !front_ready;

  wpd_thresh u_thresh (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .thr     (thr),
    .busy    (busy)
  );

  wpd_chip_level u_chip_level (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid && !busy),
    .in_ready     (front_ready),
    .sample_a     (sample_a),
    .sample_b     (sample_b),
    .sample_c     (sample_c),
    .sample_d     (sample_d),
    .symbol_start (symbol_start),
    .thr          (thr),
    .lvl          (lvl),
    .lvl_ready    (lvl_ready)
  );

  wpd_walsh u_walsh (
    .clk       (clk),
    .rst       (rst),
    .lvl       (lvl),
    .lvl_ready (lvl_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .symbol    (symbol)
  );

endmodule

>>> hdl/wpd_port_chk.sv
// Port-level checks for walsh_4pam_demodulator, attached to it by a bind statement.
// Uses wpd_pkg for port widths; sees only the top level's ports.
module wpd_port_chk (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [wpd_pkg::SYM_W-1:0]    symbol,
  input logic                         psel,
  input logic                         penable,
  input logic                         pwrite,
  input logic [wpd_pkg::PADDR_W-1:0]  paddr,
  input logic [wpd_pkg::PDATA_W-1:0]  pwdata,
  input logic [wpd_pkg::PDATA_W-1:0]  prdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(symbol))
    else $error("stalled output transaction changed or vanished");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  a_refresh_stall: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite |=> in_stall)
    else $error("input not stalled while thresholds are refreshed");

  a_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite) ##1 (paddr[2] == $past(paddr[2]))
    |-> prdata[wpd_pkg::SAMPLE_W-1:0] == $past(pwdata[wpd_pkg::SAMPLE_W-1:0]))
    else $error("register read does not return the written value");

  a_prdata_upper: assert property (@(posedge clk) disable iff (rst)
    prdata[wpd_pkg::PDATA_W-1:wpd_pkg::SAMPLE_W] == '0)
    else $error("unused register bits read as nonzero");

endmodule

bind walsh_4pam_demodulator wpd_port_chk u_port_chk (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .symbol    (symbol),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata)
);
